// ----- hw/rtl/fpvc_pkg.sv -----
// shared types and constants for the pd velocity follower
package fpvc_pkg;

   localparam int DISTANCE_DEADBAND_DEF = 100;
   localparam int ANGLE_DEADBAND_DEF    = 1000;
   localparam int GAIN_FRAC_BITS_DEF    = 16;

   localparam int GAIN_W  = 24;
   localparam int DIST_W  = 16;
   localparam int LIM_W   = 15;
   localparam int CMD_W   = 16;
   localparam int TERM_W  = 18;                  // error and difference inputs of a pd term
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   typedef enum logic [2:0] {
      REG_DEPTH_PROP  = 3'd0,
      REG_DEPTH_DIFF  = 3'd1,
      REG_ANGLE_PROP  = 3'd2,
      REG_ANGLE_DIFF  = 3'd3,
      REG_MAX_CHASE   = 3'd4,
      REG_MIN_CHASE   = 3'd5,
      REG_MAX_LINEAR  = 3'd6,
      REG_MAX_ANGULAR = 3'd7
   } reg_index_type;

   localparam logic OP_POSE = 1'b0;
   localparam logic OP_MODE = 1'b1;

   typedef struct packed {
      logic signed [GAIN_W-1:0] depth_prop_gain;
      logic signed [GAIN_W-1:0] depth_diff_gain;
      logic signed [GAIN_W-1:0] angle_prop_gain;
      logic signed [GAIN_W-1:0] angle_diff_gain;
      logic [DIST_W-1:0]        max_chase_mm;
      logic [DIST_W-1:0]        min_chase_mm;
      logic [LIM_W-1:0]         max_linear;
      logic [LIM_W-1:0]         max_angular;
   } cfg_type;

   // one item between the error stage and the pd stage
   typedef struct packed {
      logic                     zero;
      logic signed [16:0]       dist_err;
      logic signed [17:0]       dist_diff;
      logic signed [15:0]       ang_err;
      logic signed [16:0]       ang_diff;
   } job_type;

endpackage

// ----- hw/rtl/fpvc_csr.sv -----
// configuration registers behind the apb-style port
module fpvc_csr import fpvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DEPTH_PROP:  cfg_in.depth_prop_gain = csr_pwdata[GAIN_W-1:0];
            REG_DEPTH_DIFF:  cfg_in.depth_diff_gain = csr_pwdata[GAIN_W-1:0];
            REG_ANGLE_PROP:  cfg_in.angle_prop_gain = csr_pwdata[GAIN_W-1:0];
            REG_ANGLE_DIFF:  cfg_in.angle_diff_gain = csr_pwdata[GAIN_W-1:0];
            REG_MAX_CHASE:   cfg_in.max_chase_mm    = csr_pwdata[DIST_W-1:0];
            REG_MIN_CHASE:   cfg_in.min_chase_mm    = csr_pwdata[DIST_W-1:0];
            REG_MAX_LINEAR:  cfg_in.max_linear      = csr_pwdata[LIM_W-1:0];
            REG_MAX_ANGULAR: cfg_in.max_angular     = csr_pwdata[LIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DEPTH_PROP:  csr_prdata = {8'd0, cfg_ff.depth_prop_gain};
         REG_DEPTH_DIFF:  csr_prdata = {8'd0, cfg_ff.depth_diff_gain};
         REG_ANGLE_PROP:  csr_prdata = {8'd0, cfg_ff.angle_prop_gain};
         REG_ANGLE_DIFF:  csr_prdata = {8'd0, cfg_ff.angle_diff_gain};
         REG_MAX_CHASE:   csr_prdata = {16'd0, cfg_ff.max_chase_mm};
         REG_MIN_CHASE:   csr_prdata = {16'd0, cfg_ff.min_chase_mm};
         REG_MAX_LINEAR:  csr_prdata = {17'd0, cfg_ff.max_linear};
         REG_MAX_ANGULAR: csr_prdata = {17'd0, cfg_ff.max_angular};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_prop_gain <= 24'sd0;
         cfg_ff.depth_diff_gain <= 24'sd0;
         cfg_ff.angle_prop_gain <= 24'sd3277;
         cfg_ff.angle_diff_gain <= 24'sd12424;
         cfg_ff.max_chase_mm    <= 16'd3000;
         cfg_ff.min_chase_mm    <= 16'd1000;
         cfg_ff.max_linear      <= 15'd550;
         cfg_ff.max_angular     <= 15'd900;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/fpvc_front.sv -----
// pose store, error forming with deadband, last-error state and the stage register
module fpvc_front import fpvc_pkg::*; #(
   parameter int DISTANCE_DEADBAND = DISTANCE_DEADBAND_DEF,
   parameter int ANGLE_DEADBAND    = ANGLE_DEADBAND_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_fire,
   input  logic               op,
   input  logic [DIST_W-1:0]  target_distance,
   input  logic signed [15:0] target_bearing,
   input  logic               follow_mode,
   input  logic               advance,
   input  cfg_type            cfg,
   output logic               job_valid,
   output job_type            job
);

   localparam logic [16:0] DIST_DB  = 17'(DISTANCE_DEADBAND);
   localparam logic [15:0] ANGLE_DB = 16'(ANGLE_DEADBAND);

   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic signed [15:0] bear_ff, bear_in;
   logic signed [16:0] last_de_ff, last_de_in;
   logic signed [15:0] last_ae_ff, last_ae_in;
   logic               following_ff, following_in;
   logic               valid_ff, valid_in;
   job_type            job_ff, job_in;

   logic signed [16:0] de_raw, de;
   logic [16:0]        de_mag;
   logic signed [16:0] ae_neg;
   logic signed [15:0] ae_sat, ae;
   logic [15:0]        ae_mag;
   logic               follow_ev, leave_ev;

   assign de_raw = $signed({1'b0, dist_ff}) - $signed({1'b0, cfg.min_chase_mm});
   assign de_mag = de_raw[16] ? 17'(-de_raw) : de_raw;
   assign de     = (de_mag < DIST_DB) ? '0 : de_raw;

   // negated bearing saturates only for the most negative code
   assign ae_neg = -$signed({bear_ff[15], bear_ff});
   assign ae_sat = (ae_neg > 17'sd32767) ? 16'sd32767 : ae_neg[15:0];
   assign ae_mag = ae_sat[15] ? 16'(-ae_sat) : ae_sat;
   assign ae     = (ae_mag < ANGLE_DB) ? '0 : ae_sat;

   assign follow_ev = in_fire && (op == OP_MODE) && follow_mode;
   assign leave_ev  = in_fire && (op == OP_MODE) && !follow_mode && following_ff;

   always_comb begin
      dist_in      = dist_ff;
      bear_in      = bear_ff;
      last_de_in   = last_de_ff;
      last_ae_in   = last_ae_ff;
      following_in = following_ff;
      valid_in     = valid_ff && !advance;
      job_in       = job_ff;
      if (in_fire && (op == OP_POSE)) begin
         dist_in = target_distance;
         bear_in = target_bearing;
      end
      if (follow_ev) begin
         last_de_in       = de;
         last_ae_in       = ae;
         following_in     = 1'b1;
         valid_in         = 1'b1;
         job_in.zero      = dist_ff > cfg.max_chase_mm;
         job_in.dist_err  = de;
         job_in.dist_diff = {de[16], de} - {last_de_ff[16], last_de_ff};
         job_in.ang_err   = ae;
         job_in.ang_diff  = {ae[15], ae} - {last_ae_ff[15], last_ae_ff};
      end else if (leave_ev) begin
         following_in = 1'b0;
         valid_in     = 1'b1;
         job_in.zero  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff      <= '0;
         bear_ff      <= '0;
         last_de_ff   <= '0;
         last_ae_ff   <= '0;
         following_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         dist_ff      <= dist_in;
         bear_ff      <= bear_in;
         last_de_ff   <= last_de_in;
         last_ae_ff   <= last_ae_in;
         following_ff <= following_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

// ----- hw/rtl/fpvc_pd.sv -----
// one pd channel: two products, rounding to nearest and the symmetric clamp
module fpvc_pd import fpvc_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic signed [TERM_W-1:0] err,
   input  logic signed [TERM_W-1:0] diff,
   input  logic signed [GAIN_W-1:0] kp,
   input  logic signed [GAIN_W-1:0] kd,
   input  logic [LIM_W-1:0]         lim,
   input  logic                     zero,
   output logic signed [CMD_W-1:0]  cmd
);

   localparam int SUM_W = GAIN_W + TERM_W + 1;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (GAIN_FRAC_BITS - 1);

   logic signed [SUM_W-2:0] p_term, d_term;
   logic signed [SUM_W-1:0] sum, q;
   logic signed [SUM_W-1:0] lim_pos, lim_neg;

   assign p_term  = kp * err;
   assign d_term  = kd * diff;
   assign sum     = SUM_W'(p_term) + SUM_W'(d_term) + HALF;
   assign q       = sum >>> GAIN_FRAC_BITS;
   assign lim_pos = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
   assign lim_neg = -lim_pos;

   always_comb begin
      if (zero) begin
         cmd = '0;
      end else if (q > lim_pos) begin
         cmd = lim_pos[CMD_W-1:0];
      end else if (q < lim_neg) begin
         cmd = lim_neg[CMD_W-1:0];
      end else begin
         cmd = q[CMD_W-1:0];
      end
   end

endmodule

// ----- hw/rtl/follow_pd_velocity_command.sv -----
// a mode item goes to the front job register, its result to the output register
// one item per cycle unless stalled; pose items and idle mode events give no result
// the error stage register and the output register decouple the two channels
// reset clears pose, last errors and follow flag to zero and loads register defaults
// nothing is accepted in the cycle reset is high
module follow_pd_velocity_command import fpvc_pkg::*; #(
   parameter int DISTANCE_DEADBAND = DISTANCE_DEADBAND_DEF,
   parameter int ANGLE_DEADBAND    = ANGLE_DEADBAND_DEF,
   parameter int GAIN_FRAC_BITS    = GAIN_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [15:0]        req_target_distance,
   input  logic signed [15:0] req_target_bearing,
   input  logic               req_follow_mode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   cfg_type            cfg;
   job_type            job;
   logic               job_valid;
   logic               out_free, advance, in_fire;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] lin_ff, lin_in, ang_ff, ang_in;

   fpvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = job_valid && out_free;
   assign req_stall = job_valid && !out_free;
   assign in_fire   = req_valid && !req_stall && !reset;

   fpvc_front #(
      .DISTANCE_DEADBAND (DISTANCE_DEADBAND),
      .ANGLE_DEADBAND    (ANGLE_DEADBAND)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_fire         (in_fire),
      .op              (req_op),
      .target_distance (req_target_distance),
      .target_bearing  (req_target_bearing),
      .follow_mode     (req_follow_mode),
      .advance         (advance),
      .cfg             (cfg),
      .job_valid       (job_valid),
      .job             (job)
   );

   fpvc_pd #(.GAIN_FRAC_BITS (GAIN_FRAC_BITS)) u_pd_lin (
      .err  (TERM_W'(job.dist_err)),
      .diff (job.dist_diff),
      .kp   (cfg.depth_prop_gain),
      .kd   (cfg.depth_diff_gain),
      .lim  (cfg.max_linear),
      .zero (job.zero),
      .cmd  (lin_in)
   );

   fpvc_pd #(.GAIN_FRAC_BITS (GAIN_FRAC_BITS)) u_pd_ang (
      .err  (TERM_W'(job.ang_err)),
      .diff (TERM_W'(job.ang_diff)),
      .kp   (cfg.angle_prop_gain),
      .kd   (cfg.angle_diff_gain),
      .lim  (cfg.max_angular),
      .zero (job.zero),
      .cmd  (ang_in)
   );

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lin_ff <= lin_in;
         ang_ff <= ang_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_linear_cmd  = lin_ff;
   assign rsp_angular_cmd = ang_ff;

   // results never exceed the clamp limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_linear_cmd <= $signed({1'b0, cfg.max_linear})) &&
                    (rsp_linear_cmd >= -$signed({1'b0, cfg.max_linear})))
      else $error("linear command outside limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angular_cmd <= $signed({1'b0, cfg.max_angular})) &&
                    (rsp_angular_cmd >= -$signed({1'b0, cfg.max_angular})))
      else $error("angular command outside limit");

   // input side only backs up when the output register is full and held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule
